// ===== hdl/cmdh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command history ring package
// Request and status codes and the fixed field widths that the command
// history ring and its storage share.
// ----------------------------------------------------------------------------
package cmdh_pkg;

    // Fixed widths of the request and result fields.
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int CLEN_W = 12;
    localparam int BUF_W  = 12;
    localparam int ST_W   = 2;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_PREV   = 2'd1,
        REQ_NEXT   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // Status codes carried on every result.
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_BUF_SMALL = 2'd2
    } t_status;

endpackage

// ===== hdl/cmdh_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command history storage
// Holds the staging buffer for the command being typed, the line store and
// the table of line lengths. Every memory has one write port and one read
// port with a registered, enable-held read.
// ----------------------------------------------------------------------------
module cmdh_store
    import cmdh_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int MAX_LINE = 32,
    localparam int SW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int IW      = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1,
    localparam int CW      = $clog2(MAX_LINE + 1)
) (
    input  logic              i_clk,
    // Staging buffer ports.
    input  logic              i_stg_we,
    input  logic [IW-1:0]     i_stg_waddr,
    input  logic [CHAR_W-1:0] i_stg_wdata,
    input  logic              i_stg_re,
    input  logic [IW-1:0]     i_stg_raddr,
    output logic [CHAR_W-1:0] o_stg_q,
    // Line store ports, addressed by slot and character index.
    input  logic              i_line_we,
    input  logic [SW+IW-1:0]  i_line_waddr,
    input  logic [CHAR_W-1:0] i_line_wdata,
    input  logic              i_line_re,
    input  logic [SW+IW-1:0]  i_line_raddr,
    output logic [CHAR_W-1:0] o_line_q,
    // Line length table ports.
    input  logic              i_len_we,
    input  logic [SW-1:0]     i_len_waddr,
    input  logic [CW-1:0]     i_len_wdata,
    input  logic              i_len_re,
    input  logic [SW-1:0]     i_len_raddr,
    output logic [CW-1:0]     o_len_q
);

    localparam int LINE_WORDS = DEPTH * (2 ** IW);

    logic [CHAR_W-1:0] stg_mem  [MAX_LINE];
    logic [CHAR_W-1:0] line_mem [LINE_WORDS];
    logic [CW-1:0]     len_mem  [DEPTH];

    logic [CHAR_W-1:0] r_stg_q;
    logic [CHAR_W-1:0] r_line_q;
    logic [CW-1:0]     r_len_q;

    // Staging buffer: written as characters arrive, read during the copy.
    always_ff @(posedge i_clk) begin
        if (i_stg_we) begin
            stg_mem[i_stg_waddr] <= i_stg_wdata;
        end
        if (i_stg_re) begin
            r_stg_q <= stg_mem[i_stg_raddr];
        end
    end

    // Line store: filled by the copy, read while a line is recalled.
    always_ff @(posedge i_clk) begin
        if (i_line_we) begin
            line_mem[i_line_waddr] <= i_line_wdata;
        end
        if (i_line_re) begin
            r_line_q <= line_mem[i_line_raddr];
        end
    end

    // Length table: written on commit, read at the start of a recall.
    always_ff @(posedge i_clk) begin
        if (i_len_we) begin
            len_mem[i_len_waddr] <= i_len_wdata;
        end
        if (i_len_re) begin
            r_len_q <= len_mem[i_len_raddr];
        end
    end

    assign o_stg_q  = r_stg_q;
    assign o_line_q = r_line_q;
    assign o_len_q  = r_len_q;

endmodule

// ===== hdl/command_history_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command history ring
// Overwriting ring of DEPTH text lines with a browse cursor, recalled one
// character per result.
// ----------------------------------------------------------------------------
// Append characters are taken one per cycle and gathered in a staging
// buffer; the request marked last returns its status at once, and a
// committed line is then copied into the line store, during which no new
// request is taken. A previous or next request reads the length of the
// selected line as it is taken and checks it in the S_LEN state; a
// buffer-too-small or empty-line answer is loaded at the end of that
// state, and otherwise the S_STREAM state reads the line store and the
// characters follow, one per cycle while the sink keeps ready high;
// the single read port of the line store sets that pace. No new request is
// taken until the whole line has been sent. Clear, empty-history and
// end-of-history requests give one result at once. A result that waits for
// the sink holds off new requests. The stores need no clearing pass after
// reset.
module command_history_ring
    import cmdh_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int MAX_LINE = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [CHAR_W-1:0] i_in_char,
    input  logic [CLEN_W-1:0] i_cmd_length,
    input  logic              i_last_char,
    input  logic [BUF_W-1:0]  i_buf_size,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_has_char,
    output logic              o_last_result,
    output logic [ST_W-1:0]   o_status
);

    localparam int SW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW     = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int CW     = $clog2(MAX_LINE + 1);
    localparam int CURW   = $clog2(DEPTH + 1);
    localparam int BUFX_W = BUF_W + 1;

    localparam logic [SW-1:0]     SLOT_MAX  = SW'(DEPTH - 1);
    localparam logic [CW-1:0]     LINE_MAX  = CW'(MAX_LINE);
    localparam logic [CLEN_W-1:0] CLEN_MAX  = CLEN_W'(MAX_LINE);
    localparam logic [CURW-1:0]   CUR_DEPTH = CURW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_STREAM,
        S_COPY
    } t_state;

    t_state            r_state;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_has_char;
    logic              r_last_result;
    t_status           r_status;

    logic [SW-1:0]     r_oldest;
    logic [SW-1:0]     r_newest;
    logic              r_empty;
    logic [CURW-1:0]   r_cursor;
    logic [CW-1:0]     r_append_count;

    logic [SW-1:0]     r_slot;
    logic [CW-1:0]     r_len;
    logic [BUF_W-1:0]  r_buf;
    logic [CW-1:0]     r_rd_idx;
    logic [IW-1:0]     r_wr_idx;
    logic              r_pend;
    logic              r_q_last;

    t_req              req;
    logic              can_load;
    logic              in_acc;
    logic              len_ok;
    logic              stage_en;
    logic [CW-1:0]     cnt_inc;
    logic [CW-1:0]     commit_len;
    logic              commit;
    logic [SW-1:0]     new_newest;
    logic [SW-1:0]     new_oldest;
    logic [CURW-1:0]   cur_dec;
    logic [CURW-1:0]   cur_inc;
    logic [SW-1:0]     prev_slot;
    logic [SW-1:0]     next_slot;
    logic              at_end;
    logic              browse_go;
    logic [SW-1:0]     sel_slot;
    logic [CW-1:0]     len_q;
    logic [CW-1:0]     len_eff;
    logic              too_small;
    logic              res_load;
    logic              st_rd;
    logic              cp_rd;
    logic              cp_wr;
    logic [CHAR_W-1:0] stg_q;
    logic [CHAR_W-1:0] line_q;

    // Ring slot increment with wrap.
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SLOT_MAX) ? '0 : s + SW'(1);
    endfunction

    // Handshake: a request is taken only when its result has a place to go.
    assign can_load   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && can_load;
    assign in_acc     = i_in_valid && o_in_ready;
    assign req        = t_req'(i_req_type);

    // Append path: staging and commit decisions.
    assign len_ok   = (i_cmd_length <= CLEN_MAX);
    assign stage_en = in_acc && (req == REQ_APPEND) && len_ok
                      && (CLEN_W'(r_append_count) < i_cmd_length)
                      && (r_append_count < LINE_MAX);
    assign cnt_inc    = r_append_count + CW'(1);
    assign commit_len = stage_en ? cnt_inc : r_append_count;
    assign commit     = in_acc && (req == REQ_APPEND) && i_last_char && len_ok;

    // Ring indexes after a commit; the oldest line goes when the ring is full.
    always_comb begin
        if (r_empty) begin
            new_newest = '0;
            new_oldest = '0;
        end else begin
            new_newest = slot_inc(r_newest);
            new_oldest = (r_oldest == new_newest) ? slot_inc(r_oldest) : r_oldest;
        end
    end

    // Cursor navigation: slot selection for previous and next, and the end test.
    always_comb begin
        cur_dec = r_cursor - CURW'(1);
        cur_inc = r_cursor + CURW'(1);
        if (r_cursor != '0) begin
            prev_slot = SW'(cur_dec);
        end else if (r_oldest == '0) begin
            prev_slot = r_newest;
        end else begin
            prev_slot = SLOT_MAX;
        end
        if (cur_inc >= CUR_DEPTH) begin
            next_slot = SW'(cur_inc - CUR_DEPTH);
        end else begin
            next_slot = SW'(cur_inc);
        end
        at_end = (r_cursor == CURW'(r_newest))
                 || (r_cursor == CURW'(r_newest) + CURW'(1));
    end

    assign browse_go = in_acc && !r_empty
                       && ((req == REQ_PREV) || ((req == REQ_NEXT) && !at_end));
    assign sel_slot  = (req == REQ_PREV) ? prev_slot : next_slot;

    // Length check against the reader's buffer.
    assign len_eff   = (len_q > LINE_MAX) ? LINE_MAX : len_q;
    assign too_small = (BUFX_W'(len_eff) + BUFX_W'(1)) > BUFX_W'(r_buf);

    // A new result enters the output register in this cycle.
    assign res_load = (in_acc && !browse_go && ((req != REQ_APPEND) || i_last_char))
                      || ((r_state == S_LEN) && can_load
                          && (too_small || (len_eff == '0)))
                      || ((r_state == S_STREAM) && r_pend && can_load);

    // Memory sequencing for the recall stream and the commit copy.
    assign st_rd = (r_state == S_STREAM) && (r_rd_idx < r_len)
                   && (!r_pend || can_load);
    assign cp_rd = (r_state == S_COPY) && (r_rd_idx < r_len);
    assign cp_wr = (r_state == S_COPY) && r_pend;

    cmdh_store #(
        .DEPTH    (DEPTH),
        .MAX_LINE (MAX_LINE)
    ) u_store (
        .i_clk        (i_clk),
        .i_stg_we     (stage_en),
        .i_stg_waddr  (r_append_count[IW-1:0]),
        .i_stg_wdata  (i_in_char),
        .i_stg_re     (cp_rd),
        .i_stg_raddr  (r_rd_idx[IW-1:0]),
        .o_stg_q      (stg_q),
        .i_line_we    (cp_wr),
        .i_line_waddr ({r_slot, r_wr_idx}),
        .i_line_wdata (stg_q),
        .i_line_re    (st_rd),
        .i_line_raddr ({r_slot, r_rd_idx[IW-1:0]}),
        .o_line_q     (line_q),
        .i_len_we     (commit),
        .i_len_waddr  (new_newest),
        .i_len_wdata  (commit_len),
        .i_len_re     (browse_go),
        .i_len_raddr  (sel_slot),
        .o_len_q      (len_q)
    );

    // Control state machine, ring indexes and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_out_char     <= '0;
            r_has_char     <= 1'b0;
            r_last_result  <= 1'b0;
            r_status       <= ST_OK;
            r_oldest       <= '0;
            r_newest       <= '0;
            r_empty        <= 1'b1;
            r_cursor       <= '0;
            r_append_count <= '0;
            r_slot         <= '0;
            r_len          <= '0;
            r_buf          <= '0;
            r_rd_idx       <= '0;
            r_wr_idx       <= '0;
            r_pend         <= 1'b0;
            r_q_last       <= 1'b0;
        end else begin
            // The result is valid from its load until the sink takes it.
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (can_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (req)
                            REQ_APPEND: begin
                                if (i_last_char) begin
                                    r_append_count <= '0;
                                    r_out_char     <= '0;
                                    r_has_char     <= 1'b0;
                                    r_last_result  <= 1'b1;
                                    r_status       <= len_ok ? ST_OK : ST_TOO_LONG;
                                    if (len_ok) begin
                                        r_newest <= new_newest;
                                        r_oldest <= new_oldest;
                                        r_empty  <= 1'b0;
                                        r_cursor <= CURW'(new_newest) + CURW'(1);
                                        if (commit_len != '0) begin
                                            r_state  <= S_COPY;
                                            r_slot   <= new_newest;
                                            r_len    <= commit_len;
                                            r_rd_idx <= '0;
                                        end
                                    end
                                end else if (stage_en) begin
                                    r_append_count <= cnt_inc;
                                end
                            end
                            REQ_CLEAR: begin
                                r_oldest       <= '0;
                                r_newest       <= '0;
                                r_empty        <= 1'b1;
                                r_cursor       <= '0;
                                r_append_count <= '0;
                                r_out_char     <= '0;
                                r_has_char     <= 1'b0;
                                r_last_result  <= 1'b1;
                                r_status       <= ST_OK;
                            end
                            default: begin
                                if (browse_go) begin
                                    r_slot  <= sel_slot;
                                    r_buf   <= i_buf_size;
                                    r_state <= S_LEN;
                                end else begin
                                    // Empty history or end of history.
                                    r_out_char    <= '0;
                                    r_has_char    <= 1'b0;
                                    r_last_result <= 1'b1;
                                    r_status      <= ST_OK;
                                end
                            end
                        endcase
                    end
                end
                S_LEN: begin
                    if (can_load) begin
                        if (too_small) begin
                            r_out_char    <= '0;
                            r_has_char    <= 1'b0;
                            r_last_result <= 1'b1;
                            r_status      <= ST_BUF_SMALL;
                            r_state       <= S_IDLE;
                        end else begin
                            r_cursor <= CURW'(r_slot);
                            if (len_eff == '0) begin
                                r_out_char    <= '0;
                                r_has_char    <= 1'b0;
                                r_last_result <= 1'b1;
                                r_status      <= ST_OK;
                                r_state       <= S_IDLE;
                            end else begin
                                r_len    <= len_eff;
                                r_rd_idx <= '0;
                                r_state  <= S_STREAM;
                            end
                        end
                    end
                end
                S_STREAM: begin
                    // Hand the fetched character on, then fetch the next one.
                    if (r_pend && can_load) begin
                        r_out_char    <= line_q;
                        r_has_char    <= 1'b1;
                        r_last_result <= r_q_last;
                        r_status      <= ST_OK;
                        if (r_q_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                    if (st_rd) begin
                        r_pend   <= 1'b1;
                        r_rd_idx <= r_rd_idx + CW'(1);
                        r_q_last <= (r_rd_idx + CW'(1) == r_len);
                    end else if (r_pend && can_load) begin
                        r_pend <= 1'b0;
                    end
                end
                S_COPY: begin
                    // Read a character from staging, write it to the line store in the next cycle.
                    if (cp_rd) begin
                        r_pend   <= 1'b1;
                        r_wr_idx <= r_rd_idx[IW-1:0];
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (r_pend) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_has_char    = r_has_char;
    assign o_last_result = r_last_result;
    assign o_status      = r_status;

`ifndef ASSERT_OFF
    // An empty history always has both ring indexes at slot zero.
    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_newest == '0 && r_oldest == '0))
        else $error("empty history with non-zero ring indexes");

    // The staged character count never passes the line limit.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_append_count <= LINE_MAX)
        else $error("append count beyond line limit");

    // The cursor stays within one past the last slot.
    a_cursor_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CUR_DEPTH)
        else $error("cursor out of range");

    // No memory read is left in flight once the controller is idle.
    a_idle_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("read pending while idle");

    // A result that carries a character is always an ok result.
    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_has_char) |-> (r_status == ST_OK))
        else $error("character result with error status");
`endif

endmodule
